// File: hw/rtl/sddr_pkg.sv
// Shared types and constants for the sensor delta deadband reporter.
// Holds field widths, result kind codes, queue sizing and the queue entry type.
// No dependencies.
package sddr_pkg;

    // Default sizing of the sensor vector and of the per-frame report cap
    localparam int VECTOR_LENGTH_DEF = 256;
    localparam int MAX_REPORTS_DEF   = 64;

    // Field widths of the item and result channels
    localparam int SAMPLE_W = 32;
    localparam int TS_W     = 64;
    localparam int POS_W    = 8;
    localparam int DELTA_W  = 33;
    localparam int COUNT_W  = 7;
    localparam int SEQ_W    = 32;

    // Threshold register reset value, Q16.16 (about 1e-4)
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 32'd7;

    // Result kind codes
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Queue between the classifier and the result sequencer
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int USED_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified item: a delta report, a frame summary, or both
    typedef struct packed {
        logic                      report;
        logic                      summary;
        logic [POS_W-1:0]          position;
        logic signed [DELTA_W-1:0] delta;
        logic [COUNT_W-1:0]        count;
        logic [TS_W-1:0]           frame_time;
        logic [SEQ_W-1:0]          seq;
    } t_entry;

endpackage

// File: hw/rtl/sensor_delta_deadband_reporter.sv
// Sensor delta deadband reporter, top level.
// Depends on sddr_pkg, sddr_front, sddr_back and sddr_ram.
//
// Usage:
//   Samples of a sensor vector arrive one per transaction on the input queue
//   (push/full), element 0 first. Each is compared with the sample stored for
//   its element; when the absolute difference exceeds the threshold a delta
//   report comes out, at most MAX_REPORTS per frame. The last element of each
//   frame also yields a frame summary (capped count, timestamp, sequence).
//   Results leave through the output queue (empty/pop); o_last marks the
//   final result of an item.
//   Path: an accepted item passes the stage b and stage c registers and is
//   then written into the output queue, where its result shows and can be popped.
//   Throughput: one item per cycle while full is low; an item with a report
//   and a summary needs two pops. Items in the front pipeline stages b and c
//   and entries in the eight-entry queue share one budget of eight pending items.
//   full rises when eight items are pending; while pop is low results wait and
//   input is taken until that limit. Reset empties the front pipeline and the
//   output queue, sets the threshold to 7 and makes the stored vector read as
//   zero until the first frame has been written. The threshold is written through
//   i_cfg_valid/o_cfg_ready by the user only while idle; the block does not enforce it.
module sensor_delta_deadband_reporter #(
    parameter int VECTOR_LENGTH = sddr_pkg::VECTOR_LENGTH_DEF,
    parameter int MAX_REPORTS   = sddr_pkg::MAX_REPORTS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [sddr_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [sddr_pkg::TS_W-1:0]             i_timestamp,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sddr_pkg::SAMPLE_W-1:0]         i_cfg_threshold,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  o_kind,
    output logic [sddr_pkg::POS_W-1:0]            o_position,
    output logic signed [sddr_pkg::DELTA_W-1:0]   o_delta,
    output logic [sddr_pkg::COUNT_W-1:0]          o_report_count,
    output logic [sddr_pkg::TS_W-1:0]             o_frame_time,
    output logic [sddr_pkg::SEQ_W-1:0]            o_sequence_res,
    output logic                                  o_last
);

    import sddr_pkg::*;

    logic   w_enq;
    logic   w_retire;
    t_entry w_entry;

    // Accept and classify
    sddr_front #(
        .VECTOR_LENGTH (VECTOR_LENGTH),
        .MAX_REPORTS   (MAX_REPORTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample        (i_sample),
        .i_timestamp     (i_timestamp),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_threshold (i_cfg_threshold),
        .i_retire        (w_retire),
        .o_enq           (w_enq),
        .o_entry         (w_entry)
    );

    // Queue and deliver results
    sddr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enq          (w_enq),
        .i_entry        (w_entry),
        .o_retire       (w_retire),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_position     (o_position),
        .o_delta        (o_delta),
        .o_report_count (o_report_count),
        .o_frame_time   (o_frame_time),
        .o_sequence_res (o_sequence_res),
        .o_last         (o_last)
    );

endmodule

// File: hw/rtl/sddr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents when read and write hit the same address.
// No dependencies.
module sddr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read before write, registered output
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sddr_front.sv
// Front end of the deadband reporter: accepts samples, looks up the stored
// sample, forms the delta and classifies each item into a queue entry.
// Depends on sddr_pkg and sddr_ram.
module sddr_front #(
    parameter int VECTOR_LENGTH = sddr_pkg::VECTOR_LENGTH_DEF,
    parameter int MAX_REPORTS   = sddr_pkg::MAX_REPORTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [sddr_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [sddr_pkg::TS_W-1:0]              i_timestamp,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sddr_pkg::SAMPLE_W-1:0]          i_cfg_threshold,
    input  logic                                   i_retire,
    output logic                                   o_enq,
    output sddr_pkg::t_entry                       o_entry
);

    import sddr_pkg::*;

    localparam int IW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam int CW = $clog2(MAX_REPORTS + 1);
    localparam logic [IW-1:0] LAST_IDX   = IW'(VECTOR_LENGTH - 1);
    localparam logic [CW-1:0] REPORT_CAP = CW'(MAX_REPORTS);

    // Control state
    logic [SAMPLE_W-1:0] r_thr;
    logic [IW-1:0]       r_idx;
    logic                r_fresh;
    logic                r_b_valid;
    logic                r_c_valid;
    logic [CW-1:0]       r_reports;
    logic [SEQ_W-1:0]    r_seq;
    logic [USED_W-1:0]   r_used;
    logic [USED_W-1:0]   n_used;

    // Pipeline payload
    logic signed [SAMPLE_W-1:0] r_b_sample;
    logic [TS_W-1:0]            r_b_ts;
    logic [IW-1:0]              r_b_idx;
    logic                       r_b_end;
    logic                       r_b_fresh;
    logic signed [DELTA_W-1:0]  r_c_delta;
    logic [TS_W-1:0]            r_c_ts;
    logic [IW-1:0]              r_c_idx;
    logic                       r_c_end;

    logic                       w_accept;
    logic                       w_end;
    logic [SAMPLE_W-1:0]        w_old;
    logic signed [DELTA_W-1:0]  w_old_ext;
    logic signed [DELTA_W-1:0]  w_diff;
    logic [DELTA_W-1:0]         w_mag;
    logic                       w_over;
    logic                       w_report;
    logic [CW-1:0]              w_count;
    logic                       w_drop;

    assign w_accept    = push && !full;
    assign w_end       = (r_idx == LAST_IDX);
    assign o_cfg_ready = 1'b1;

    // Hold admission while every queue slot is claimed by a pending item
    assign full = (r_used == USED_W'(QUEUE_DEPTH));

    // Stored vector: read the old sample and write the new one in the accept cycle
    sddr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (VECTOR_LENGTH),
        .AW    (IW)
    ) u_prev (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_idx),
        .i_wdata (i_sample),
        .i_re    (w_accept),
        .i_raddr (r_idx),
        .o_rdata (w_old)
    );

    // Difference against the stored sample; untouched entries read as zero
    assign w_old_ext = r_b_fresh ? '0 : $signed({w_old[SAMPLE_W-1], w_old});
    assign w_diff    = $signed({r_b_sample[SAMPLE_W-1], r_b_sample}) - w_old_ext;

    // Deadband test and report cap
    assign w_mag    = r_c_delta[DELTA_W-1] ? DELTA_W'(-r_c_delta) : DELTA_W'(r_c_delta);
    assign w_over   = (w_mag > {1'b0, r_thr});
    assign w_report = r_c_valid && w_over && (r_reports < REPORT_CAP);
    assign w_count  = r_reports + CW'(w_report);
    assign o_enq    = r_c_valid && (w_report || r_c_end);
    assign w_drop   = r_c_valid && !o_enq;

    always_comb begin
        o_entry            = '0;
        o_entry.report     = w_report;
        o_entry.summary    = r_c_end;
        o_entry.position   = POS_W'(r_c_idx);
        o_entry.delta      = r_c_delta;
        o_entry.count      = COUNT_W'(w_count);
        o_entry.frame_time = r_c_ts;
        o_entry.seq        = r_seq + 1'b1;
    end

    // Track items in flight plus queued entries
    assign n_used = r_used + USED_W'(w_accept) - USED_W'(w_drop) - USED_W'(i_retire);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESHOLD_RESET;
            r_idx     <= '0;
            r_fresh   <= 1'b1;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_reports <= '0;
            r_seq     <= '0;
            r_used    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_threshold;
            end
            if (w_accept) begin
                r_idx <= w_end ? '0 : r_idx + 1'b1;
                if (w_end) begin
                    r_fresh <= 1'b0;
                end
            end
            r_b_valid <= w_accept;
            r_c_valid <= r_b_valid;
            if (r_c_valid) begin
                r_reports <= r_c_end ? '0 : w_count;
                if (r_c_end) begin
                    r_seq <= r_seq + 1'b1;
                end
            end
            r_used <= n_used;
        end
    end

    // Pipeline payload, advanced every cycle
    always_ff @(posedge i_clk) begin
        r_b_sample <= i_sample;
        r_b_ts     <= i_timestamp;
        r_b_idx    <= r_idx;
        r_b_end    <= w_end;
        r_b_fresh  <= r_fresh;
        r_c_delta  <= w_diff;
        r_c_ts     <= r_b_ts;
        r_c_idx    <= r_b_idx;
        r_c_end    <= r_b_end;
    end

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(QUEUE_DEPTH))
        else $error("front: pending item count above queue depth");

    a_end_enqueued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_end) |-> o_enq)
        else $error("front: frame end item not enqueued");

    a_cap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reports <= REPORT_CAP)
        else $error("front: report count above cap");

    a_stage_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 r_c_valid)
        else $error("front: accepted item lost in pipeline");
`endif

endmodule

// File: hw/rtl/sddr_back.sv
// Back end of the deadband reporter: queues classified entries and hands out
// their results, a delta report before the frame summary when both exist.
// Depends on sddr_pkg.
module sddr_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_enq,
    input  sddr_pkg::t_entry                      i_entry,
    output logic                                  o_retire,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  o_kind,
    output logic [sddr_pkg::POS_W-1:0]            o_position,
    output logic signed [sddr_pkg::DELTA_W-1:0]   o_delta,
    output logic [sddr_pkg::COUNT_W-1:0]          o_report_count,
    output logic [sddr_pkg::TS_W-1:0]             o_frame_time,
    output logic [sddr_pkg::SEQ_W-1:0]            o_sequence_res,
    output logic                                  o_last
);

    import sddr_pkg::*;

    t_entry              r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [USED_W-1:0]   r_cnt;
    logic                r_phase;

    t_entry w_head;
    logic   w_pair;
    logic   w_show_report;
    logic   w_pop_ok;

    assign w_head        = r_q[r_rp];
    assign w_pair        = w_head.report && w_head.summary;
    assign w_show_report = w_head.report && !r_phase;
    assign empty         = (r_cnt == '0);
    assign w_pop_ok      = pop && !empty;

    // Retire the entry with its final result
    assign o_retire = w_pop_ok && !(w_pair && !r_phase);

    // Present the current result of the head entry
    assign o_kind         = w_show_report ? KIND_REPORT : KIND_SUMMARY;
    assign o_position     = w_show_report ? w_head.position : '0;
    assign o_delta        = w_show_report ? w_head.delta : '0;
    assign o_report_count = w_show_report ? '0 : w_head.count;
    assign o_frame_time   = w_show_report ? '0 : w_head.frame_time;
    assign o_sequence_res = w_show_report ? '0 : w_head.seq;
    assign o_last         = w_show_report ? !w_head.summary : 1'b1;

    // Queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else begin
            if (i_enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (o_retire) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + USED_W'(i_enq) - USED_W'(o_retire);
            if (w_pop_ok) begin
                r_phase <= w_pair && !r_phase;
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_q[r_wp] <= i_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_enq && !o_retire && (r_cnt == USED_W'(QUEUE_DEPTH))))
        else $error("back: enqueue into full queue");

    a_phase_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!empty && w_pair))
        else $error("back: summary phase without a paired entry");

    a_pair_two_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_ok && w_pair && !r_phase) |=> (r_phase && !empty))
        else $error("back: paired entry left before its summary");
`endif

endmodule
